### hdl/time_slot_histogram_peak_core_macros.svh
// assertion macros for the slot histogram block
`ifndef TIME_SLOT_HISTOGRAM_PEAK_CORE_MACROS_SVH
`define TIME_SLOT_HISTOGRAM_PEAK_CORE_MACROS_SVH

// same-cycle implication, inactive during reset
`define TSHP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, inactive during reset
`define TSHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/tshp_pkg.sv
`timescale 1ns / 1ps

package tshp_pkg;

    // fixed field widths
    localparam int CNT_W      = 16;
    localparam int MINUTE_W   = 11;
    localparam int DAY_W      = 9;
    localparam int OUT_SLOT_W = 7;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DAYS  = 1'b1;
    localparam logic [CNT_W-1:0]     MIN_COUNT_RESET = 16'd3;
    localparam logic [CNT_W-1:0]     MIN_DAYS_RESET  = 16'd3;

    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [DAY_W-1:0] day_t;

    typedef enum logic [1:0] {
        CMD_RECORD = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_STATUS = 2'd2
    } cmd_t;

    // running statistics kept beside the counter store
    typedef struct packed {
        cnt_t event_total;
        cnt_t day_total;
        cnt_t best_count;
        day_t last_day;
        logic last_day_valid;
    } stats_t;

    // result fields other than the slot index and the peak slot
    typedef struct packed {
        logic                recorded;
        cnt_t                slot_count;
        cnt_t                total_events;
        cnt_t                observed_days;
        cnt_t                peak_count;
        logic                peak_found;
        logic [MINUTE_W-1:0] peak_centre_minute;
        logic                reliable;
    } result_t;

    function automatic cnt_t sat_inc(input cnt_t v);
        return (v == CNT_MAX) ? v : cnt_t'(v + 16'd1);
    endfunction

endpackage

### hdl/time_slot_histogram_peak_core.sv
`timescale 1ns / 1ps

// Saturating time-slot histogram with peak tracking. Each item (record, clear or
// status) gives exactly one result. One item is taken every clock cycle when the
// output is not stalled. The counter RAM is read at the edge that takes the item
// into stage one; when stage one advances, the read-modify-write, statistics
// update and loading of the result into the output register follow, with the
// write-back forwarded to a following item of the same slot. Counters are cleared
// at once through a valid bit per slot, so there is no clearing pass after reset
// or clear.
// Configuration is written through cfg_wr_en / cfg_index / cfg_wdata; the user
// must write it only while the block is idle, as the block does not enforce this.
module time_slot_histogram_peak_core #(
    parameter int NUM_SLOTS        = 96,
    parameter int MINUTES_PER_SLOT = 15
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration port
    input  logic                                 cfg_wr_en,
    input  logic [tshp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tshp_pkg::CNT_W-1:0]           cfg_wdata,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           cmd,
    input  logic                                 time_known,
    input  logic [tshp_pkg::MINUTE_W-1:0]        minute_of_day,
    input  logic [tshp_pkg::DAY_W-1:0]           day_of_year,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 recorded,
    output logic [tshp_pkg::OUT_SLOT_W-1:0]      slot_index,
    output logic [tshp_pkg::CNT_W-1:0]           slot_count,
    output logic [tshp_pkg::CNT_W-1:0]           total_events,
    output logic [tshp_pkg::CNT_W-1:0]           observed_days,
    output logic [tshp_pkg::OUT_SLOT_W-1:0]      peak_slot,
    output logic [tshp_pkg::CNT_W-1:0]           peak_count,
    output logic                                 peak_found,
    output logic [tshp_pkg::MINUTE_W-1:0]        peak_centre_minute,
    output logic                                 reliable
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);

    // configuration registers
    tshp_pkg::cnt_t min_count_reg;
    tshp_pkg::cnt_t min_days_reg;

    // stage one: item waiting on the RAM read
    logic                 s1_valid_reg;
    tshp_pkg::cmd_t       s1_cmd_reg;
    logic                 s1_known_reg;
    logic                 s1_in_range_reg;
    logic [SLOT_W-1:0]    s1_slot_reg;
    tshp_pkg::day_t       s1_day_reg;
    logic                 fwd_reg;
    tshp_pkg::cnt_t       fwd_count_reg;

    // histogram state
    logic [NUM_SLOTS-1:0] slot_valid_reg;
    tshp_pkg::stats_t     stats_reg;
    logic [SLOT_W-1:0]    best_slot_reg;

    // output register
    logic                 out_valid_reg;
    tshp_pkg::result_t    result_reg;
    logic [SLOT_W-1:0]    slot_index_reg;
    logic [SLOT_W-1:0]    peak_slot_reg;

    logic                 accept;
    logic                 s1_advance;
    logic [SLOT_W-1:0]    map_slot;
    logic                 map_in_range;
    tshp_pkg::cnt_t       rd_count;
    tshp_pkg::cnt_t       cur_count;
    logic                 do_record;
    logic                 do_clear;
    logic                 wr_en;
    tshp_pkg::cnt_t       new_count;
    tshp_pkg::stats_t     stats_next;
    logic [SLOT_W-1:0]    best_slot_next;
    logic [SLOT_W-1:0]    slot_out;
    tshp_pkg::result_t    result;

    // handshake
    assign s1_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign accept     = in_valid && !in_stall;
    assign wr_en      = s1_advance && do_record;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_count_reg <= tshp_pkg::MIN_COUNT_RESET;
            min_days_reg  <= tshp_pkg::MIN_DAYS_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                tshp_pkg::REG_MIN_COUNT: min_count_reg <= cfg_wdata;
                tshp_pkg::REG_MIN_DAYS:  min_days_reg  <= cfg_wdata;
                default:                 min_days_reg  <= min_days_reg;
            endcase
        end
    end

    tshp_slot_map #(
        .NUM_SLOTS        (NUM_SLOTS),
        .MINUTES_PER_SLOT (MINUTES_PER_SLOT)
    ) u_slot_map (
        .minute_of_day (minute_of_day),
        .slot          (map_slot),
        .in_range      (map_in_range)
    );

    tshp_ram #(
        .WIDTH (tshp_pkg::CNT_W),
        .DEPTH (NUM_SLOTS)
    ) u_counter_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_slot_reg),
        .wr_data (new_count),
        .rd_en   (accept),
        .rd_addr (map_slot),
        .rd_data (rd_count)
    );

    // stage one control and forwarding of a same-slot write-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_reg      <= wr_en && (s1_slot_reg == map_slot);
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // stage one payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg      <= tshp_pkg::cmd_t'(cmd);
            s1_known_reg    <= time_known;
            s1_in_range_reg <= map_in_range;
            s1_slot_reg     <= map_slot;
            s1_day_reg      <= day_of_year;
            fwd_count_reg   <= new_count;
        end
    end

    // counter value before this item: forwarded, stored or cleared
    always_comb
    begin
        priority if (fwd_reg)
        begin
            cur_count = fwd_count_reg;
        end
        else if (s1_in_range_reg && slot_valid_reg[s1_slot_reg])
        begin
            cur_count = rd_count;
        end
        else
        begin
            cur_count = '0;
        end
    end

    tshp_update #(
        .NUM_SLOTS        (NUM_SLOTS),
        .MINUTES_PER_SLOT (MINUTES_PER_SLOT)
    ) u_update (
        .cmd            (s1_cmd_reg),
        .time_known     (s1_known_reg),
        .in_range       (s1_in_range_reg),
        .slot           (s1_slot_reg),
        .day            (s1_day_reg),
        .cur_count      (cur_count),
        .stats          (stats_reg),
        .best_slot      (best_slot_reg),
        .min_count      (min_count_reg),
        .min_days       (min_days_reg),
        .do_record      (do_record),
        .do_clear       (do_clear),
        .new_count      (new_count),
        .stats_next     (stats_next),
        .best_slot_next (best_slot_next),
        .slot_out       (slot_out),
        .result         (result)
    );

    // histogram state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            stats_reg      <= '0;
            best_slot_reg  <= '0;
        end
        else if (s1_advance)
        begin
            stats_reg     <= stats_next;
            best_slot_reg <= best_slot_next;
            if (do_clear)
            begin
                slot_valid_reg <= '0;
            end
            else if (do_record)
            begin
                slot_valid_reg[s1_slot_reg] <= 1'b1;
            end
        end
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            result_reg     <= result;
            slot_index_reg <= slot_out;
            peak_slot_reg  <= best_slot_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign recorded           = result_reg.recorded;
    assign slot_index         = tshp_pkg::OUT_SLOT_W'(slot_index_reg);
    assign slot_count         = result_reg.slot_count;
    assign total_events       = result_reg.total_events;
    assign observed_days      = result_reg.observed_days;
    assign peak_slot          = tshp_pkg::OUT_SLOT_W'(peak_slot_reg);
    assign peak_count         = result_reg.peak_count;
    assign peak_found         = result_reg.peak_found;
    assign peak_centre_minute = result_reg.peak_centre_minute;
    assign reliable           = result_reg.reliable;

endmodule

### hdl/tshp_ram.sv
`timescale 1ns / 1ps

module tshp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 96
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hdl/tshp_slot_map.sv
`timescale 1ns / 1ps

module tshp_slot_map #(
    parameter int NUM_SLOTS        = 96,
    parameter int MINUTES_PER_SLOT = 15
) (
    input  logic [tshp_pkg::MINUTE_W-1:0]  minute_of_day,
    output logic [$clog2(NUM_SLOTS)-1:0]   slot,
    output logic                           in_range
);

    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    // 2^DIV_SHIFT exceeds the largest minute times the slot length, so the quotient is exact
    localparam int DIV_SHIFT = 22;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int PROD_W    = RECIP_W + tshp_pkg::MINUTE_W;
    localparam longint RECIP = ((64'd1 << DIV_SHIFT) + MINUTES_PER_SLOT - 1) / MINUTES_PER_SLOT;

    logic [PROD_W-1:0]             prod;
    logic [tshp_pkg::MINUTE_W-1:0] quot;

    // divide by the slot length through a reciprocal multiply
    assign prod     = {{RECIP_W{1'b0}}, minute_of_day} * PROD_W'(RECIP);
    assign quot     = prod[DIV_SHIFT +: tshp_pkg::MINUTE_W];
    assign in_range = quot < tshp_pkg::MINUTE_W'(NUM_SLOTS);
    assign slot     = quot[SLOT_W-1:0];

endmodule

### hdl/tshp_update.sv
`timescale 1ns / 1ps

module tshp_update #(
    parameter int NUM_SLOTS        = 96,
    parameter int MINUTES_PER_SLOT = 15
) (
    input  tshp_pkg::cmd_t                cmd,
    input  logic                          time_known,
    input  logic                          in_range,
    input  logic [$clog2(NUM_SLOTS)-1:0]  slot,
    input  tshp_pkg::day_t                day,
    input  tshp_pkg::cnt_t                cur_count,
    input  tshp_pkg::stats_t              stats,
    input  logic [$clog2(NUM_SLOTS)-1:0]  best_slot,
    input  tshp_pkg::cnt_t                min_count,
    input  tshp_pkg::cnt_t                min_days,
    output logic                          do_record,
    output logic                          do_clear,
    output tshp_pkg::cnt_t                new_count,
    output tshp_pkg::stats_t              stats_next,
    output logic [$clog2(NUM_SLOTS)-1:0]  best_slot_next,
    output logic [$clog2(NUM_SLOTS)-1:0]  slot_out,
    output tshp_pkg::result_t             result
);

    localparam int SLOT_W   = $clog2(NUM_SLOTS);
    localparam int CENTRE_W = 18;

    logic [CENTRE_W-1:0] centre_full;
    logic                found;

    assign do_record = (cmd == tshp_pkg::CMD_RECORD) && time_known && in_range;
    assign do_clear  = (cmd == tshp_pkg::CMD_CLEAR);
    assign new_count = tshp_pkg::sat_inc(cur_count);

    // statistics and peak tracking
    always_comb
    begin
        stats_next     = stats;
        best_slot_next = best_slot;
        priority if (do_record)
        begin
            stats_next.event_total = tshp_pkg::sat_inc(stats.event_total);
            if (!stats.last_day_valid || (day != stats.last_day))
            begin
                stats_next.last_day       = day;
                stats_next.last_day_valid = 1'b1;
                stats_next.day_total      = tshp_pkg::sat_inc(stats.day_total);
            end
            if ((new_count > stats.best_count) ||
                ((new_count == stats.best_count) && (slot < best_slot)))
            begin
                stats_next.best_count = new_count;
                best_slot_next        = slot;
            end
        end
        else if (do_clear)
        begin
            stats_next.event_total = '0;
            stats_next.day_total   = '0;
            stats_next.best_count  = '0;
            best_slot_next         = '0;
        end
        else
        begin
            stats_next = stats;
        end
    end

    // centre minute of the peak slot
    assign centre_full = CENTRE_W'(best_slot_next) * CENTRE_W'(MINUTES_PER_SLOT)
                       + CENTRE_W'(MINUTES_PER_SLOT / 2);

    assign found = (stats_next.best_count != '0);

    // result fields
    always_comb
    begin
        result.recorded           = do_record;
        result.slot_count         = do_record ? new_count : '0;
        result.total_events       = stats_next.event_total;
        result.observed_days      = stats_next.day_total;
        result.peak_count         = stats_next.best_count;
        result.peak_found         = found;
        result.peak_centre_minute = centre_full[tshp_pkg::MINUTE_W-1:0];
        result.reliable           = found && (stats_next.best_count >= min_count)
                                  && (stats_next.day_total >= min_days);
    end

    assign slot_out = do_record ? slot : SLOT_W'(0);

endmodule

### hdl/tshp_checker.sv
`timescale 1ns / 1ps
`include "time_slot_histogram_peak_core_macros.svh"

module tshp_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic                            recorded,
    input logic [tshp_pkg::OUT_SLOT_W-1:0] slot_index,
    input logic [tshp_pkg::CNT_W-1:0]      slot_count,
    input logic [tshp_pkg::CNT_W-1:0]      total_events,
    input logic [tshp_pkg::CNT_W-1:0]      peak_count,
    input logic                            peak_found
);

    logic unrec_clean;
    logic rec_consistent;

    assign unrec_clean    = (slot_index == '0) && (slot_count == '0);
    // the day count may stay zero when a clear kept the same last day
    assign rec_consistent = (slot_count != '0) && (total_events != '0)
                          && (peak_count >= slot_count);

    // an item that was not counted reports no slot
    `TSHP_ASSERT_NOW(a_unrecorded_zero, clk, rst_n, out_valid && !recorded, unrec_clean, "slot data on unrecorded transfer")

    // a counted event leaves a nonzero total and a peak at least as high as its slot
    `TSHP_ASSERT_NOW(a_recorded_totals, clk, rst_n, out_valid && recorded, rec_consistent, "inconsistent recorded transfer")

    // peak flag follows the peak count
    `TSHP_ASSERT_NOW(a_peak_found, clk, rst_n, out_valid, peak_found == (peak_count != '0), "peak_found disagrees")

    // a stalled result holds
    `TSHP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(slot_count) && $stable(peak_count), "stalled result changed")

endmodule

bind time_slot_histogram_peak_core tshp_checker u_tshp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .recorded      (recorded),
    .slot_index    (slot_index),
    .slot_count    (slot_count),
    .total_events  (total_events),
    .peak_count    (peak_count),
    .peak_found    (peak_found)
);
